// ===== rtl/core/damped_fractional_comb_filter_defines.svh =====
// assertion macros for the damped fractional comb filter
// expects clk and rst_n in the scope of each use
`ifndef DAMPED_FRACTIONAL_COMB_FILTER_DEFINES_SVH
`define DAMPED_FRACTIONAL_COMB_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DFCF_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dfcf assertion failed");
`define DFCF_ASSERT_NEXT(name, trig, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error("dfcf assertion failed");
`else
`define DFCF_ASSERT(name, prop)
`define DFCF_ASSERT_NEXT(name, trig, expr)
`endif

`endif

// ===== rtl/core/dfcf_pkg.sv =====
// shared types, constants, microcode table and arithmetic helpers
// for the damped fractional comb filter; no dependencies
package dfcf_pkg;

    localparam int DEPTH       = 4096;
    localparam int FRAC_BITS   = 8;
    localparam int SAMPLE_BITS = 24;

    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int POS_W    = ADDR_W + FRAC_BITS;
    localparam int DELAY_W  = 20;
    localparam int GAIN_W   = 15;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SAMPLE_BITS + COEF_W + 1;
    localparam int ACC_W    = PROD_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int STEP_W   = 4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic [FRAC_BITS-1:0]          frac_t;
    typedef logic [COEF_W-1:0]             coef_t;
    typedef logic [STEP_W-1:0]             step_t;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 2'd2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(25600);
    localparam logic [DELAY_W-1:0] DELAY_MIN   = DELAY_W'(1 << FRAC_BITS);
    localparam logic [DELAY_W-1:0] DELAY_MAX   = DELAY_W'((DEPTH - 2) << FRAC_BITS);
    localparam logic [GAIN_W-1:0]  FEEDBACK_MAX = GAIN_W'(32604);
    localparam logic [GAIN_W-1:0]  DAMPING_MAX  = GAIN_W'(32440);
    localparam coef_t FRAC_ONE = COEF_W'(1 << FRAC_BITS);
    localparam coef_t Q15_ONE  = COEF_W'(32768);

    localparam sample_t SAMPLE_MAX = sample_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam sample_t SAMPLE_MIN = sample_t'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    typedef enum logic [1:0] {RD_NONE, RD_TAP0, RD_TAP1} rd_sel_t;
    typedef enum logic [1:0] {OPA_RDATA, OPA_TMP, OPA_LP} opa_sel_t;
    typedef enum logic [2:0] {OPB_NFRAC, OPB_FRAC, OPB_NDAMP, OPB_DAMP, OPB_FB} opb_sel_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
    typedef enum logic [1:0] {COND_NEXT, COND_IN, COND_OUT} cond_t;

    typedef struct packed {
        rd_sel_t  rd;
        opa_sel_t opa;
        opb_sel_t opb;
        acc_op_t  acc_op;
        logic     tmp_ld;
        logic     lp_ld;
        logic     fin;
        cond_t    cond;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } stat_t;

    localparam step_t ST_WAIT    = 4'd0;
    localparam step_t ST_TAP1    = 4'd1;
    localparam step_t ST_TAP2    = 4'd2;
    localparam step_t ST_INTERP  = 4'd3;
    localparam step_t ST_DELAYED = 4'd4;
    localparam step_t ST_LP_A    = 4'd5;
    localparam step_t ST_LP_B    = 4'd6;
    localparam step_t ST_LP_SUM  = 4'd7;
    localparam step_t ST_LP_RND  = 4'd8;
    localparam step_t ST_GAIN    = 4'd9;
    localparam step_t ST_FINISH  = 4'd10;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t cw;
        cw = '{rd: RD_NONE, opa: OPA_RDATA, opb: OPB_FB, acc_op: ACC_HOLD,
               tmp_ld: 1'b0, lp_ld: 1'b0, fin: 1'b0, cond: COND_NEXT};
        case (step)
            ST_WAIT:
            begin
                cw.rd   = RD_TAP0;
                cw.cond = COND_IN;
            end
            ST_TAP1:
            begin
                cw.rd  = RD_TAP1;
                cw.opa = OPA_RDATA;
                cw.opb = OPB_NFRAC;
            end
            ST_TAP2:
            begin
                cw.opa    = OPA_RDATA;
                cw.opb    = OPB_FRAC;
                cw.acc_op = ACC_LOAD;
            end
            ST_INTERP:  cw.acc_op = ACC_ADD;
            ST_DELAYED: cw.tmp_ld = 1'b1;
            ST_LP_A:
            begin
                cw.opa = OPA_TMP;
                cw.opb = OPB_NDAMP;
            end
            ST_LP_B:
            begin
                cw.opa    = OPA_LP;
                cw.opb    = OPB_DAMP;
                cw.acc_op = ACC_LOAD;
            end
            ST_LP_SUM:  cw.acc_op = ACC_ADD;
            ST_LP_RND:  cw.lp_ld = 1'b1;
            ST_GAIN:
            begin
                cw.opa = OPA_LP;
                cw.opb = OPB_FB;
            end
            ST_FINISH:
            begin
                cw.opa  = OPA_LP;
                cw.opb  = OPB_FB;
                cw.fin  = 1'b1;
                cw.cond = COND_OUT;
            end
            default:    cw.cond = COND_OUT;
        endcase
        return cw;
    endfunction

    // add half an lsb, then arithmetic shift
    function automatic acc_t rnd_shift(input acc_t v, input int sh);
        acc_t half;
        half = acc_t'(1) <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    function automatic sample_t sat_sample(input acc_t v);
        sample_t r;
        if (v > acc_t'(SAMPLE_MAX))
            r = SAMPLE_MAX;
        else if (v < acc_t'(SAMPLE_MIN))
            r = SAMPLE_MIN;
        else
            r = sample_t'(v);
        return r;
    endfunction

endpackage

// ===== rtl/core/dfcf_if.sv =====
// sample, result and configuration channel interfaces
// depends on dfcf_pkg for field widths
interface dfcf_in_if;
    logic                    valid;
    logic                    ready;
    dfcf_pkg::sample_t       sample_in;
    logic                    block_end;
    modport source (output valid, sample_in, block_end, input ready);
    modport sink (input valid, sample_in, block_end, output ready);
endinterface

interface dfcf_out_if;
    logic                    valid;
    logic                    ready;
    dfcf_pkg::sample_t       sample_out;
    logic                    block_end_out;
    modport source (output valid, sample_out, block_end_out, input ready);
    modport sink (input valid, sample_out, block_end_out, output ready);
endinterface

interface dfcf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dfcf_pkg::CFG_IDX_W-1:0]     index;
    logic [dfcf_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dfcf_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module dfcf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dfcf_seq.sv =====
// microcode sequencer: step counter, control rom lookup and jumps
// depends on dfcf_pkg and the assertion macro header
`include "damped_fractional_comb_filter_defines.svh"

module dfcf_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  dfcf_pkg::stat_t st,
    output dfcf_pkg::ctrl_t ctrl
);

    dfcf_pkg::step_t step_reg;
    dfcf_pkg::step_t step_next;

    assign ctrl = dfcf_pkg::ucode(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            dfcf_pkg::COND_IN:
                step_next = st.in_valid ? step_reg + dfcf_pkg::STEP_W'(1) : step_reg;
            dfcf_pkg::COND_OUT:
                step_next = st.out_free ? dfcf_pkg::ST_WAIT : step_reg;
            default:
                step_next = step_reg + dfcf_pkg::STEP_W'(1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= dfcf_pkg::ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    `DFCF_ASSERT(a_step_range, step_reg <= dfcf_pkg::ST_FINISH)
    `DFCF_ASSERT_NEXT(a_accept_starts, ctrl.cond == dfcf_pkg::COND_IN && st.in_valid, step_reg == dfcf_pkg::ST_TAP1)
    `DFCF_ASSERT_NEXT(a_finish_returns, ctrl.cond == dfcf_pkg::COND_OUT && st.out_free, step_reg == dfcf_pkg::ST_WAIT)

endmodule

// ===== rtl/core/dfcf_dpath.sv =====
// datapath: config registers, tap addressing, shared multiplier,
// accumulator, lowpass state and output register; depends on dfcf_pkg
`include "damped_fractional_comb_filter_defines.svh"

module dfcf_dpath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dfcf_pkg::ctrl_t            ctrl,
    output dfcf_pkg::stat_t            st,
    dfcf_in_if.sink                    samples,
    dfcf_out_if.source                 results,
    dfcf_cfg_if.sink                   cfg,
    output logic                       ram_we,
    output dfcf_pkg::addr_t            ram_waddr,
    output logic [dfcf_pkg::SAMPLE_BITS-1:0] ram_wdata,
    output dfcf_pkg::addr_t            ram_raddr,
    input  logic [dfcf_pkg::SAMPLE_BITS-1:0] ram_rdata
);

    logic [dfcf_pkg::DELAY_W-1:0] delay_reg;
    logic [dfcf_pkg::GAIN_W-1:0]  fb_reg;
    logic [dfcf_pkg::GAIN_W-1:0]  damp_reg;

    dfcf_pkg::addr_t   wp_reg;
    dfcf_pkg::addr_t   wp_next;
    logic              filled_reg;
    logic              rvalid_reg;
    logic              rvalid_next;
    dfcf_pkg::sample_t lp_reg;
    logic              out_valid_reg;

    dfcf_pkg::sample_t x_reg;
    logic              end_reg;
    dfcf_pkg::addr_t   tap1_reg;
    dfcf_pkg::frac_t   frac_reg;
    logic signed [dfcf_pkg::PROD_W-1:0] prod_reg;
    dfcf_pkg::acc_t    acc_reg;
    dfcf_pkg::sample_t tmp_reg;
    dfcf_pkg::sample_t out_sample_reg;
    logic              out_end_reg;

    logic [dfcf_pkg::DELAY_W-1:0] delay_cl;
    logic [dfcf_pkg::GAIN_W-1:0]  fb_cl;
    logic [dfcf_pkg::GAIN_W-1:0]  damp_cl;
    logic [dfcf_pkg::POS_W-1:0]   pos;
    dfcf_pkg::addr_t   tap0;
    logic              accept;
    logic              fire;
    dfcf_pkg::sample_t op_a;
    dfcf_pkg::coef_t   op_b;
    dfcf_pkg::acc_t    prod_ext;
    dfcf_pkg::sample_t y;

    assign cfg.ready     = 1'b1;
    assign samples.ready = (ctrl.cond == dfcf_pkg::COND_IN);
    assign accept        = samples.valid && samples.ready;
    assign st.in_valid   = samples.valid;
    assign st.out_free   = !out_valid_reg || results.ready;
    assign fire          = ctrl.fin && st.out_free;

    // clamp the registers as they are used
    always_comb
    begin
        if (delay_reg < dfcf_pkg::DELAY_MIN)
            delay_cl = dfcf_pkg::DELAY_MIN;
        else if (delay_reg > dfcf_pkg::DELAY_MAX)
            delay_cl = dfcf_pkg::DELAY_MAX;
        else
            delay_cl = delay_reg;
        fb_cl   = (fb_reg > dfcf_pkg::FEEDBACK_MAX) ? dfcf_pkg::FEEDBACK_MAX : fb_reg;
        damp_cl = (damp_reg > dfcf_pkg::DAMPING_MAX) ? dfcf_pkg::DAMPING_MAX : damp_reg;
    end

    // read position wraps naturally in the address plus fraction width
    assign pos  = {wp_reg, dfcf_pkg::FRAC_BITS'(0)} - dfcf_pkg::POS_W'(delay_cl);
    assign tap0 = pos[dfcf_pkg::POS_W-1:dfcf_pkg::FRAC_BITS];

    // entries not yet written since reset read as zero
    always_comb
    begin
        case (ctrl.rd)
            dfcf_pkg::RD_TAP0:
            begin
                ram_raddr   = tap0;
                rvalid_next = filled_reg || (tap0 < wp_reg);
            end
            dfcf_pkg::RD_TAP1:
            begin
                ram_raddr   = tap1_reg;
                rvalid_next = filled_reg || (tap1_reg < wp_reg);
            end
            default:
            begin
                ram_raddr   = tap1_reg;
                rvalid_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (ctrl.opa)
            dfcf_pkg::OPA_RDATA: op_a = rvalid_reg ? $signed(ram_rdata) : '0;
            dfcf_pkg::OPA_TMP:   op_a = tmp_reg;
            dfcf_pkg::OPA_LP:    op_a = lp_reg;
            default:             op_a = '0;
        endcase
        case (ctrl.opb)
            dfcf_pkg::OPB_NFRAC: op_b = dfcf_pkg::FRAC_ONE - dfcf_pkg::COEF_W'(frac_reg);
            dfcf_pkg::OPB_FRAC:  op_b = dfcf_pkg::COEF_W'(frac_reg);
            dfcf_pkg::OPB_NDAMP: op_b = dfcf_pkg::Q15_ONE - dfcf_pkg::COEF_W'(damp_cl);
            dfcf_pkg::OPB_DAMP:  op_b = dfcf_pkg::COEF_W'(damp_cl);
            dfcf_pkg::OPB_FB:    op_b = dfcf_pkg::COEF_W'(fb_cl);
            default:             op_b = '0;
        endcase
    end

    assign prod_ext = dfcf_pkg::acc_t'(prod_reg);
    assign y = dfcf_pkg::sat_sample(dfcf_pkg::acc_t'(x_reg) + dfcf_pkg::rnd_shift(prod_ext, 15));

    assign wp_next   = fire ? wp_reg + dfcf_pkg::ADDR_W'(1) : wp_reg;
    assign ram_we    = fire;
    assign ram_waddr = wp_reg;
    assign ram_wdata = y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= dfcf_pkg::DELAY_RESET;
            fb_reg        <= '0;
            damp_reg      <= '0;
            wp_reg        <= '0;
            filled_reg    <= 1'b0;
            rvalid_reg    <= 1'b0;
            lp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    dfcf_pkg::REG_DELAY:    delay_reg <= cfg.data[dfcf_pkg::DELAY_W-1:0];
                    dfcf_pkg::REG_FEEDBACK: fb_reg <= cfg.data[dfcf_pkg::GAIN_W-1:0];
                    dfcf_pkg::REG_DAMPING:  damp_reg <= cfg.data[dfcf_pkg::GAIN_W-1:0];
                    default:                delay_reg <= delay_reg;
                endcase
            end
            rvalid_reg <= rvalid_next;
            wp_reg     <= wp_next;
            if (fire && (wp_reg == dfcf_pkg::addr_t'(dfcf_pkg::DEPTH - 1)))
            begin
                filled_reg <= 1'b1;
            end
            if (ctrl.lp_ld)
            begin
                lp_reg <= dfcf_pkg::sat_sample(dfcf_pkg::rnd_shift(acc_reg, 15));
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= samples.sample_in;
            end_reg  <= samples.block_end;
            tap1_reg <= tap0 + dfcf_pkg::ADDR_W'(1);
            frac_reg <= pos[dfcf_pkg::FRAC_BITS-1:0];
        end
        prod_reg <= $signed(op_a) * $signed({1'b0, op_b});
        case (ctrl.acc_op)
            dfcf_pkg::ACC_LOAD: acc_reg <= prod_ext;
            dfcf_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            default:            acc_reg <= acc_reg;
        endcase
        if (ctrl.tmp_ld)
        begin
            tmp_reg <= dfcf_pkg::sat_sample(dfcf_pkg::rnd_shift(acc_reg, dfcf_pkg::FRAC_BITS));
        end
        if (fire)
        begin
            out_sample_reg <= y;
            out_end_reg    <= end_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.sample_out    = out_sample_reg;
    assign results.block_end_out = out_end_reg;

    `DFCF_ASSERT_NEXT(a_write_loads_out, ram_we, out_valid_reg)
    `DFCF_ASSERT_NEXT(a_write_moves_ptr, ram_we, wp_reg == $past(wp_reg) + dfcf_pkg::ADDR_W'(1))
    `DFCF_ASSERT_NEXT(a_ptr_holds, !ram_we, $stable(wp_reg))
    `DFCF_ASSERT_NEXT(a_filled_sticks, filled_reg, filled_reg)

endmodule

// ===== rtl/core/damped_fractional_comb_filter.sv =====
// damped fractional comb filter top level: sequencer, datapath, delay line ram
// the program reads both taps, interpolates, lowpasses and scales, then registers the result
// one sample at a time: a new one is accepted only in the wait step, the program
// sharing one multiplier and one ram read port; finish waits while results stall
// reset: async active low, delay line reads zero until written, no clearing pass
module damped_fractional_comb_filter (
    input  logic        clk,
    input  logic        rst_n,
    dfcf_in_if.sink     samples,
    dfcf_out_if.source  results,
    dfcf_cfg_if.sink    cfg
);

    dfcf_pkg::ctrl_t ctrl;
    dfcf_pkg::stat_t st;
    logic            ram_we;
    dfcf_pkg::addr_t ram_waddr;
    dfcf_pkg::addr_t ram_raddr;
    logic [dfcf_pkg::SAMPLE_BITS-1:0] ram_wdata;
    logic [dfcf_pkg::SAMPLE_BITS-1:0] ram_rdata;

    dfcf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctrl  (ctrl)
    );

    dfcf_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .st        (st),
        .samples   (samples),
        .results   (results),
        .cfg       (cfg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dfcf_ram #(
        .WIDTH (dfcf_pkg::SAMPLE_BITS),
        .DEPTH (dfcf_pkg::DEPTH)
    ) u_delay_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
